// ----- src/mtc_pkg.sv -----
// Package for the MIDI time code system message decoder.
// Holds the decoder state type, status codes and range limits; no dependencies.
`default_nettype none

package mtc_pkg;

    typedef struct packed {
        logic [7:0]  frames;
        logic [7:0]  seconds;
        logic [7:0]  minutes;
        logic [4:0]  hours;
        logic [1:0]  rate;
        logic [2:0]  piece;
        logic        valid;
        logic        playing;
        logic [15:0] errors;
        logic [15:0] quarters;
    } t_mtc_state;

    localparam logic [7:0] ST_QUARTER_FRAME = 8'hF1;
    localparam logic [7:0] ST_CLOCK         = 8'hF8;
    localparam logic [7:0] ST_START         = 8'hFA;
    localparam logic [7:0] ST_CONTINUE      = 8'hFB;
    localparam logic [7:0] ST_STOP          = 8'hFC;
    localparam logic [7:0] ST_SYSTEM_RESET  = 8'hFF;

    localparam logic [2:0] PIECE_FRAMES_LO  = 3'd0;
    localparam logic [2:0] PIECE_FRAMES_HI  = 3'd1;
    localparam logic [2:0] PIECE_SECONDS_LO = 3'd2;
    localparam logic [2:0] PIECE_SECONDS_HI = 3'd3;
    localparam logic [2:0] PIECE_MINUTES_LO = 3'd4;
    localparam logic [2:0] PIECE_MINUTES_HI = 3'd5;
    localparam logic [2:0] PIECE_HOURS_LO   = 3'd6;
    localparam logic [2:0] PIECE_HOURS_RATE = 3'd7;

    localparam logic [7:0]  FRAME_LIMIT  = 8'd30;
    localparam logic [7:0]  SECOND_LIMIT = 8'd60;
    localparam logic [7:0]  MINUTE_LIMIT = 8'd60;
    localparam logic [4:0]  HOUR_LIMIT   = 5'd24;
    localparam logic [15:0] ERROR_MAX    = 16'hFFFF;

endpackage

`default_nettype wire

// ----- src/mtc_update.sv -----
// Next-state logic of the MIDI time code decoder for one system message.
// Depends on mtc_pkg for the state type, status codes and range limits.
`default_nettype none

module mtc_update
    import mtc_pkg::*;
(
    input  t_mtc_state i_state,
    input  logic [7:0] i_status_byte,
    input  logic [6:0] i_data_byte,
    output t_mtc_state o_state
);

    logic [2:0] piece;
    logic [3:0] nib;
    t_mtc_state qf;
    logic       in_range;

    assign piece = i_data_byte[6:4];
    assign nib   = i_data_byte[3:0];

    always_comb begin
        qf = i_state;
        unique case (piece)
            PIECE_FRAMES_LO:  qf.frames[3:0]  = nib;
            PIECE_FRAMES_HI:  qf.frames[7:4]  = nib;
            PIECE_SECONDS_LO: qf.seconds[3:0] = nib;
            PIECE_SECONDS_HI: qf.seconds[7:4] = nib;
            PIECE_MINUTES_LO: qf.minutes[3:0] = nib;
            PIECE_MINUTES_HI: qf.minutes[7:4] = nib;
            PIECE_HOURS_LO:   qf.hours[3:0]   = nib;
            default: begin
                qf.hours[4] = nib[0];
                qf.rate     = nib[2:1];
            end
        endcase
        qf.piece    = piece;
        qf.quarters = i_state.quarters + 16'd1;
        in_range = (qf.frames < FRAME_LIMIT) && (qf.seconds < SECOND_LIMIT)
                && (qf.minutes < MINUTE_LIMIT) && (qf.hours < HOUR_LIMIT);
        if (piece == PIECE_HOURS_RATE) begin
            qf.valid = in_range;
            if (!in_range && (i_state.errors != ERROR_MAX)) begin
                qf.errors = i_state.errors + 16'd1;
            end
        end
    end

    always_comb begin
        o_state = i_state;
        unique case (i_status_byte) inside
            ST_QUARTER_FRAME: o_state = qf;
            ST_CLOCK, ST_START, ST_CONTINUE: o_state.playing = 1'b1;
            ST_STOP: o_state.playing = 1'b0;
            ST_SYSTEM_RESET: begin
                o_state.frames  = '0;
                o_state.seconds = '0;
                o_state.minutes = '0;
                o_state.hours   = '0;
                o_state.rate    = '0;
                o_state.piece   = '0;
                o_state.valid   = 1'b0;
                o_state.playing = 1'b0;
            end
            default: o_state = i_state;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/midi_timecode_system_decoder_top.sv -----
// Top level of the MIDI time code system message decoder.
// Depends on mtc_pkg and mtc_update; holds the input register and the state/result register.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_status_byte, i_data_byte
//   result   out        o_valid / i_ready    o_playing .. o_quarter_frame_total
//
// One transaction per cycle sustained while i_ready is high; each passes the input register, then the result register.
// The result fields are the decoder state itself, updated when a transaction leaves
// the input register, so a stalled result holds the state steady.
// Synchronous active-low reset clears the decoder state and both valid flags (not the input byte registers).
// o_ready stays high while the input register is empty or its transaction is moving on.
`default_nettype none

module midi_timecode_system_decoder_top
    import mtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_status_byte,
    input  logic [6:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_playing,
    output logic        o_timecode_valid,
    output logic [7:0]  o_frame_count,
    output logic [7:0]  o_second_count,
    output logic [7:0]  o_minute_count,
    output logic [4:0]  o_hour_count,
    output logic [1:0]  o_rate_code,
    output logic [2:0]  o_last_piece,
    output logic [15:0] o_error_total,
    output logic [15:0] o_quarter_frame_total
);

    logic       r_in_valid;
    logic [7:0] r_status;
    logic [6:0] r_data;
    logic       r_out_valid;
    t_mtc_state r_state;
    t_mtc_state n_state;
    logic       advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    mtc_update u_update (
        .i_state       (r_state),
        .i_status_byte (r_status),
        .i_data_byte   (r_data),
        .o_state       (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_status <= i_status_byte;
            r_data   <= i_data_byte;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_playing             = r_state.playing;
    assign o_timecode_valid      = r_state.valid;
    assign o_frame_count         = r_state.frames;
    assign o_second_count        = r_state.seconds;
    assign o_minute_count        = r_state.minutes;
    assign o_hour_count          = r_state.hours;
    assign o_rate_code           = r_state.rate;
    assign o_last_piece          = r_state.piece;
    assign o_error_total         = r_state.errors;
    assign o_quarter_frame_total = r_state.quarters;

endmodule

`default_nettype wire
